[hdl/lrupr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by the frame cell and the top level.
package lrupr_pkg;

  // Width of the frame count written over the config channel.
  localparam int unsigned CFG_W = 4;

  // Control broadcast from the top level to every frame cell.
  typedef struct packed {
    logic update;    // reference accepted this cycle
    logic clear;     // configuration write: drop all frames
    logic restart;   // reference carries the restart flag
    logic miss;      // no active cell matched
    logic use_free;  // a free active cell exists
  } cell_ctl_t;

  // Status each cell reports back.
  typedef struct packed {
    logic match;       // holds the referenced page
    logic first_free;  // lowest free active cell
    logic target;      // cell takes the referenced page
    logic valid_eff;   // valid after restart is applied
  } cell_stat_t;

endpackage

[hdl/lrupr_cell.sv]
// One frame cell: page tag, valid bit and recency rank.
// Depends on lrupr_pkg; instantiated once per frame by the top level.
module lrupr_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned RANK_W    = 3,
  parameter int unsigned CNT_W     = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrupr_pkg::cell_ctl_t   ctl,
  input  logic [PAGE_BITS-1:0]   page,
  input  logic [RANK_W-1:0]      hit_rank,
  input  logic [RANK_W-1:0]      lru_rank,
  input  logic [CNT_W-1:0]       active_n,
  input  logic                   prev_valid,
  output lrupr_pkg::cell_stat_t  stat,
  output logic [PAGE_BITS-1:0]   page_q,
  output logic [RANK_W-1:0]      rank_q
);
  import lrupr_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic                 active, is_lru, age;

  always_comb begin
    active          = active_n > CNT_W'(IDX);
    stat.valid_eff  = valid_r & ~ctl.restart;
    stat.match      = active & stat.valid_eff & (page_r == page);
    stat.first_free = active & ~stat.valid_eff & prev_valid;
    is_lru          = active & stat.valid_eff & (rank_r == lru_rank);
    if (ctl.miss) begin
      stat.target = ctl.use_free ? stat.first_free : is_lru;
    end else begin
      stat.target = stat.match;
    end
    // age every younger valid cell; on a miss every other valid cell ages
    age = stat.valid_eff & ~stat.target & (ctl.miss | (rank_r < hit_rank));

    valid_nxt = valid_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.update) begin
      valid_nxt = stat.valid_eff | stat.target;
      if (stat.target) begin
        rank_nxt = '0;
        if (ctl.miss) begin
          page_nxt = page;
        end
      end else if (age) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    rank_r <= rank_nxt;
  end

  assign page_q = page_r;
  assign rank_q = rank_r;

endmodule

[hdl/lru_page_replacement_top.sv]
// Top level of the fully associative LRU page replacement block.
// Depends on lrupr_pkg and lrupr_cell (one cell per frame).
//
// Usage:
// - Input channel (in_valid/in_ready): one word per page reference,
//   in_page_number plus in_restart, which clears all frames and the fault
//   total before the reference is handled.
// - Output channel (out_valid/out_ready): one word per reference with hit,
//   frame slot, evicted page and the running saturating fault total.
// - Config channel (cfg_valid/cfg_ready): writes the frame count; 0 acts as
//   one frame, values above FRAMES act as FRAMES. A write drops every frame
//   and keeps the fault total. cfg_ready is always high; write only while
//   no reference is in flight.
// Timing: a reference is looked up in all cells at once and the cells
// update at the accept edge; the result is registered and shows next
// cycle. One reference per cycle is sustained while out_ready is high;
// lookup, target choice and rank update in the cells are combinational.
// Reset: all frames empty, fault total zero, frame count min(FRAMES, 8).
// Stall: while out_ready is low the result holds in the output register
// and in_ready drops until the result is taken or being taken.
module lru_page_replacement_top #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [PAGE_BITS-1:0]                        in_page_number,
  input  logic                                        in_restart,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic                                        out_hit,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] out_frame_slot,
  output logic                                        out_evicted_valid,
  output logic [PAGE_BITS-1:0]                        out_evicted_page,
  output logic [31:0]                                 out_fault_total,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]                 cfg_frame_count
);
  import lrupr_pkg::*;

  localparam int unsigned SLOT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned RANK_W  = SLOT_W;
  localparam int unsigned CNT_W   = $clog2(FRAMES + 1);
  localparam int unsigned RST_CNT = (FRAMES < 8) ? FRAMES : 8;

  cell_ctl_t             ctl;
  cell_stat_t            stat [FRAMES];
  logic [PAGE_BITS-1:0]  cell_page [FRAMES];
  logic [RANK_W-1:0]     cell_rank [FRAMES];
  logic [FRAMES:0]       valid_chain;

  logic [CNT_W-1:0]      active_n_r, active_n_nxt;
  logic [RANK_W-1:0]     lru_rank_r, lru_rank_nxt;
  logic [31:0]           fault_r, fault_nxt, fault_base;

  logic                  accept, any_match, any_free;
  logic [RANK_W-1:0]     hit_rank;
  logic [SLOT_W-1:0]     slot_sel;
  logic [PAGE_BITS-1:0]  evict_sel;

  logic                  out_valid_r, out_valid_nxt;
  logic                  hit_r, evv_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [PAGE_BITS-1:0]  evp_r;
  logic [31:0]           total_r;

  // Accept a reference whenever the output register is free or draining.
  assign in_ready  = ~out_valid_r | out_ready;
  assign accept    = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // Gather the match, free and rank lines from the row of cells.
  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    hit_rank  = '0;
    for (int j = 0; j < FRAMES; j++) begin
      any_match = any_match | stat[j].match;
      any_free  = any_free | stat[j].first_free;
      hit_rank  = hit_rank | (stat[j].match ? cell_rank[j] : '0);
    end
  end

  always_comb begin
    ctl.update   = accept;
    ctl.clear    = cfg_valid & cfg_ready;
    ctl.restart  = in_restart;
    ctl.miss     = ~any_match;
    ctl.use_free = any_free;
  end

  // Cell 0 always sees a valid neighbor, so it is first free when empty.
  assign valid_chain[0] = 1'b1;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .IDX       (g),
      .PAGE_BITS (PAGE_BITS),
      .RANK_W    (RANK_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .page       (in_page_number),
      .hit_rank   (hit_rank),
      .lru_rank   (lru_rank_r),
      .active_n   (active_n_r),
      .prev_valid (valid_chain[g]),
      .stat       (stat[g]),
      .page_q     (cell_page[g]),
      .rank_q     (cell_rank[g])
    );
    assign valid_chain[g+1] = stat[g].valid_eff;
  end

  // Encode the single target cell; the evicted page comes from it too.
  always_comb begin
    slot_sel  = '0;
    evict_sel = '0;
    for (int j = 0; j < FRAMES; j++) begin
      slot_sel  = slot_sel | (stat[j].target ? SLOT_W'(j) : '0);
      evict_sel = evict_sel | ((stat[j].target & stat[j].valid_eff) ? cell_page[j] : '0);
    end
  end

  // Fault total: restart zeroes it first, a miss adds one up to saturation.
  always_comb begin
    fault_base = in_restart ? '0 : fault_r;
    fault_nxt  = fault_r;
    if (accept) begin
      fault_nxt = fault_base;
      if (ctl.miss && (fault_base != '1)) begin
        fault_nxt = fault_base + 32'd1;
      end
    end
  end

  // Frame count write: clamp to the built range, keep n and n-1 ready.
  always_comb begin
    active_n_nxt = active_n_r;
    lru_rank_nxt = lru_rank_r;
    if (cfg_valid && cfg_ready) begin
      priority if (cfg_frame_count == '0) begin
        active_n_nxt = CNT_W'(1);
      end else if (32'(cfg_frame_count) > FRAMES) begin
        active_n_nxt = CNT_W'(FRAMES);
      end else begin
        active_n_nxt = CNT_W'(cfg_frame_count);
      end
      lru_rank_nxt = RANK_W'(active_n_nxt - CNT_W'(1));
    end
  end

  assign out_valid_nxt = accept | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_n_r  <= CNT_W'(RST_CNT);
      lru_rank_r  <= RANK_W'(RST_CNT - 1);
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_n_r  <= active_n_nxt;
      lru_rank_r  <= lru_rank_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r   <= any_match;
      slot_r  <= slot_sel;
      evv_r   <= ctl.miss & ~any_free;
      evp_r   <= (ctl.miss & ~any_free) ? evict_sel : '0;
      total_r <= fault_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_frame_slot    = slot_r;
  assign out_evicted_valid = evv_r;
  assign out_evicted_page  = evp_r;
  assign out_fault_total   = total_r;

endmodule

[hdl/lrupr_checker.sv]
// Port-level checks for the LRU page replacement block, bound to the top.
// Depends only on the top level's ports.
module lrupr_checker #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_valid,
  input logic                                        in_ready,
  input logic                                        in_restart,
  input logic                                        out_valid,
  input logic                                        out_ready,
  input logic                                        out_hit,
  input logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] out_frame_slot,
  input logic                                        out_evicted_valid,
  input logic [PAGE_BITS-1:0]                        out_evicted_page,
  input logic [31:0]                                 out_fault_total
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_slot)
      && $stable(out_fault_total) && $stable(out_hit))
    else $error("result word changed while stalled");

  // Every accepted reference shows a result on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("result missing one cycle after accept");

  // A hit never evicts, and no eviction reports a nonzero page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
    else $error("hit reported with eviction");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  // After restart the fault total is the reference's own fault at most.
  a_restart_total: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart |=> out_fault_total == {31'd0, !out_hit})
    else $error("fault total not restarted");

endmodule

bind lru_page_replacement_top lrupr_checker #(
  .FRAMES    (FRAMES),
  .PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_restart        (in_restart),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit           (out_hit),
  .out_frame_slot    (out_frame_slot),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_total   (out_fault_total)
);

[dv/lru_page_replacement_top_tb.sv]
// Self-checking testbench for lru_page_replacement_top: page references are
// driven over valid/ready and every result word is checked against an LRU predictor.
// Depends on lrupr_pkg and the RTL under hdl/.
module lru_page_replacement_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  localparam int unsigned FRAMES    = 8;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned MAX_SHOWN = 10;

  // Receiver behavior: always ready, random stalls (ready 55% of the time), or a fixed stall window.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  // Expected content of one result word.
  typedef struct packed {
    logic                 hit;
    logic [2:0]           slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [31:0]          total;
  } lru_outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PAGE_BITS-1:0] in_page_number = '0;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_hit;
  logic [2:0]           out_frame_slot;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [31:0]          out_fault_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_frame_count = '0;

  rx_mode_t rx_mode = RX_ALWAYS;
  logic [7:0] rx_tick = '0;

  // Outcomes still owed by the block, oldest first.
  lru_outcome_t replace_outcomes[$];

  // Shadow copy of the frame table.
  logic [PAGE_BITS-1:0] shadow_page[FRAMES];
  bit                   shadow_valid[FRAMES];
  int unsigned          shadow_rank[FRAMES];
  logic [31:0]          shadow_faults;
  logic [CFG_W-1:0]     shadow_frames;

  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned n_refs = 0;
  int unsigned n_hits = 0;
  int unsigned n_evicts = 0;
  int unsigned n_restarts = 0;
  int unsigned n_cfg = 0;

  lru_page_replacement_top #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page_number   (in_page_number),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_frame_slot   (out_frame_slot),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_frame_count  (cfg_frame_count)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drop every frame; rank order restarts from empty.
  function automatic void drop_frames();
    for (int j = 0; j < FRAMES; j++) begin
      shadow_page[j]  = '0;
      shadow_valid[j] = 1'b0;
      shadow_rank[j]  = 0;
    end
  endfunction

  // Frames actually in use: 0 behaves as 1, anything above FRAMES as FRAMES.
  function automatic int live_frames();
    if (shadow_frames == 0) return 1;
    if (shadow_frames > FRAMES) return FRAMES;
    return shadow_frames;
  endfunction

  // Promote slot s to most recent; every valid slot younger than it ages by one.
  function automatic void promote(int s, int unsigned old_rank);
    for (int j = 0; j < FRAMES; j++) begin
      if (j != s && shadow_valid[j] && shadow_rank[j] < old_rank)
        shadow_rank[j]++;
    end
    shadow_rank[s] = 0;
  endfunction

  // Apply one reference to the shadow table and return what the block must report.
  function automatic lru_outcome_t replace_page(logic [PAGE_BITS-1:0] page, logic restart);
    lru_outcome_t r;
    int           n;
    int           s;
    bit           found;
    bit           has_free;
    int unsigned  oldest;
    r        = '0;
    n        = live_frames();
    s        = 0;
    found    = 1'b0;
    has_free = 1'b0;
    if (restart) begin
      drop_frames();
      shadow_faults = '0;
    end
    for (int j = 0; j < n; j++) begin
      if (!found && shadow_valid[j] && shadow_page[j] == page) begin
        s     = j;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      promote(s, shadow_rank[s]);
    end else begin
      for (int j = 0; j < n; j++) begin
        if (!has_free && !shadow_valid[j]) begin
          s        = j;
          has_free = 1'b1;
        end
      end
      if (has_free) begin
        shadow_valid[s] = 1'b1;
        shadow_page[s]  = page;
        promote(s, FRAMES + 1);
      end else begin
        // Table full: the highest rank is the least recently used page.
        oldest = 0;
        s      = 0;
        for (int j = 0; j < n; j++) begin
          if (shadow_rank[j] >= oldest) begin
            oldest = shadow_rank[j];
            s      = j;
          end
        end
        r.ev_valid     = 1'b1;
        r.ev_page      = shadow_page[s];
        shadow_page[s] = page;
        promote(s, shadow_rank[s]);
      end
      if (shadow_faults != 32'hFFFF_FFFF) shadow_faults++;
    end
    r.slot  = s[2:0];
    r.total = shadow_faults;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one reference word. The sender runs in bursts; at the start of a burst
  // it may drop valid for a random gap. Valid stays high after the accept so
  // back-to-back words never toggle it within one step.
  task automatic send_ref(logic [PAGE_BITS-1:0] page, logic restart);
    lru_outcome_t want;
    int unsigned  gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_page_number <= page;
    in_restart     <= restart;
    do @(posedge clk); while (!in_ready);
    want = replace_page(page, restart);
    replace_outcomes = {replace_outcomes, want};
    n_refs++;
    if (want.hit) n_hits++;
    if (want.ev_valid) n_evicts++;
    if (restart) n_restarts++;
  endtask

  // Hold off new words until every owed result has come back, plus slack for
  // the result register.
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (replace_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the frame count while the block is idle; the write empties the table
  // but keeps the fault total.
  task automatic write_frame_count(logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_frame_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    shadow_frames = value;
    drop_frames();
    n_cfg++;
  endtask

  // Receiver stall pattern, advanced every cycle.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    case (rx_mode)
      RX_ALWAYS: begin
        out_ready <= 1'b1;
      end
      RX_RANDOM: begin
        out_ready <= ($urandom_range(0, 99) < 55);
      end
      default: begin
        // Stall while the low four bits of the tick are below three, and also
        // while its low six bits are 58 or above.
        out_ready <= (rx_tick[3:0] > 4'd2) && (rx_tick[5:0] < 6'd58);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result word with the oldest outcome.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lru_outcome_t want;
    lru_outcome_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{hit: out_hit, slot: out_frame_slot, ev_valid: out_evicted_valid,
              ev_page: out_evicted_page, total: out_fault_total};
      if (replace_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("[%0t] unexpected result word: hit=%0b slot=%0d ev=%0b/%h total=%0d",
                   $realtime, got.hit, got.slot, got.ev_valid, got.ev_page, got.total);
      end else begin
        want = replace_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("[%0t] result mismatch: want hit=%0b slot=%0d ev=%0b/%h total=%0d",
                     $realtime, want.hit, want.slot, want.ev_valid, want.ev_page,
                     want.total);
            $display("    got hit=%0b slot=%0d ev=%0b/%h total=%0d",
                     got.hit, got.slot, got.ev_valid, got.ev_page, got.total);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration (eight frames): page 0 on an empty table must miss,
  // extreme page values, hits, filling every slot, LRU eviction, and a restart
  // on a resident page, which must fault again.
  task automatic test_directed_refs();
    rx_mode <= RX_ALWAYS;
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h4321, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'hFFFF, 1'b1);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
  endtask

  // Frame count extremes: 0 behaves as one frame (every new page evicts the
  // last), 15 clamps to eight, and the write keeps the fault total.
  task automatic test_frame_limits();
    rx_mode <= RX_RANDOM;
    write_frame_count(4'd0);
    send_ref(16'h00F0, 1'b0);
    send_ref(16'h0F00, 1'b0);
    send_ref(16'h0F00, 1'b0);
    send_ref(16'h00F0, 1'b0);
    write_frame_count(4'd15);
    for (int k = 0; k < 10; k++) send_ref(16'h3000 + k[15:0] % 9, 1'b0);
    write_frame_count(4'd1);
    send_ref(16'hBEEF, 1'b0);
    send_ref(16'hBEEF, 1'b0);
    send_ref(16'hCAFE, 1'b1);
  endtask

  // Random references over a small working set per phase so that hits, fills
  // and evictions all occur; some references go anywhere in the page space and
  // a few carry restart.
  task automatic test_random_refs();
    logic [CFG_W-1:0]     settings[] = '{4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
                                         4'd7, 4'd0, 4'd15, 4'd9, 4'd12};
    logic [PAGE_BITS-1:0] pool[24];
    int                   pool_size;
    int                   roll;
    logic [PAGE_BITS-1:0] page;
    for (int ph = 0; ph < settings.size() + 1; ph++) begin
      if (ph < settings.size()) write_frame_count(settings[ph]);
      else write_frame_count(CFG_W'($urandom_range(0, 15)));
      rx_mode   <= rx_mode_t'(ph % 3);
      pool_size = live_frames() + $urandom_range(0, live_frames() + 1);
      for (int k = 0; k < pool_size; k++) pool[k] = PAGE_BITS'($urandom_range(0, 65535));
      for (int k = 0; k < 32; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) page = PAGE_BITS'($urandom_range(0, 65535));
        else page = pool[$urandom_range(0, pool_size - 1)];
        send_ref(page, roll < 3);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow_faults = '0;
    shadow_frames = 4'd8;
    drop_frames();
    // Hold reset low, then release it on a clock edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_refs();
    test_frame_limits();
    test_random_refs();

    drain_results();
    repeat (8) @(posedge clk);
    if (replace_outcomes.size() != 0) begin
      mismatches += replace_outcomes.size();
      $display("%0d result words never arrived", replace_outcomes.size());
    end

    $display("Run covered %0d references (%0d hits, %0d evictions, %0d restarts)",
             n_refs, n_hits, n_evicts, n_restarts);
    $display("across %0d frame-count writes; %0d words disagreed", n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("Timeout waiting for the block");
    $display("Mismatches found");
    $finish;
  end

endmodule
